// File: design/frame_time_quality_governor_top_assert.svh
// Assertion macros for the frame time quality governor.
// Taken in by the modules that carry concurrent checks; needs nothing else.
`ifndef FRAME_TIME_QUALITY_GOVERNOR_TOP_ASSERT_SVH
`define FRAME_TIME_QUALITY_GOVERNOR_TOP_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define FTQG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ftqg assertion failed");
// Next-cycle implication, checked outside reset.
`define FTQG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ftqg assertion failed");
`else
`define FTQG_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FTQG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/ftqg_pkg.sv
// Shared types and constants of the frame time quality governor.
// Used by the top level and the window; depends on nothing.
package ftqg_pkg;

    // Field widths.
    localparam int FRAME_W   = 32;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 3;
    localparam int RATE_W    = 20;
    localparam int FRAMES_W  = 16;
    localparam int ELAPSED_W = 33;
    localparam int NUMER_W   = 40;
    localparam int CD_W      = 16;

    // Default window length.
    localparam int WINDOW_LEN_DEF = 60;

    // Rate measurement constants.
    localparam logic [ELAPSED_W-1:0] ONE_SECOND_US = ELAPSED_W'(1000000);
    localparam logic [23:0]          RATE_SCALE    = 24'd16000000;
    localparam logic [RATE_W-1:0]    RATE_MAX      = '1;
    localparam logic [FRAMES_W-1:0]  FRAMES_MAX    = '1;

    // Quality levels.
    localparam logic [1:0] LVL_LOW  = 2'd0;
    localparam logic [1:0] LVL_MED  = 2'd1;
    localparam logic [1:0] LVL_HIGH = 2'd2;

    // Quality change codes.
    localparam logic [1:0] CHG_NONE    = 2'd0;
    localparam logic [1:0] CHG_LOWERED = 2'd1;
    localparam logic [1:0] CHG_RAISED  = 2'd2;

    // Register reset values.
    localparam logic             RST_ADAPTIVE = 1'b1;
    localparam logic [1:0]       RST_MANUAL   = 2'd2;
    localparam logic [19:0]      RST_SLOW     = 20'd20004;
    localparam logic [19:0]      RST_FAST     = 20'd13336;
    localparam logic [CD_W-1:0]  RST_LOWER_CD = 16'd180;
    localparam logic [CD_W-1:0]  RST_RAISE_CD = 16'd300;

    // Register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ADAPTIVE = 3'd0,
        REG_MANUAL   = 3'd1,
        REG_SLOW     = 3'd2,
        REG_FAST     = 3'd3,
        REG_LOWER_CD = 3'd4,
        REG_RAISE_CD = 3'd5
    } t_reg_idx;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_ADD,
        S_START,
        S_DIV,
        S_GOV,
        S_PUT
    } t_state;

    // Window store controls.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_win_ctrl;

endpackage

// File: design/frame_time_quality_governor_top.sv
// Frame time quality governor: top level with sequencer and governor.
// Uses ftqg_pkg, ftqg_window, ftqg_serial_div and the assertion header.
//
// Usage:
// The input channel (i_valid, o_stall, i_now_us) takes one frame timestamp
// per item. The output channel (o_valid, i_stall and the o_ result fields)
// returns one result item per input item: frame time, window average,
// measured rate, rate-updated flag, quality level and quality change.
// Each item runs through a window update and two bit-serial divisions that
// work side by side: the average divider handles one bit of the window total
// per cycle and the rate divider works through its 40-bit numerator, which
// sets the pace. The sequencer steps through read, add, start, divide, govern
// and put, and a new item is accepted only once it is back in idle.
// o_stall is high while an item is being worked on. A finished result sits
// in an output register; if the receiver stalls, the next result waits in
// the block until that register frees up.
// Reset (synchronous, active low) restores the register defaults, clears the
// window, the rate counters and the cooldown, and sets the level to high.
// Configuration writes are taken at any edge with i_cfg_we high.
`include "frame_time_quality_governor_top_assert.svh"

module frame_time_quality_governor_top
    import ftqg_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // Input channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [FRAME_W-1:0]   i_now_us,
    // Output channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [FRAME_W-1:0]   o_frame_time_us,
    output logic [FRAME_W-1:0]   o_average_time_us,
    output logic [RATE_W-1:0]    o_fps_q4,
    output logic                 o_fps_updated,
    output logic [1:0]           o_quality_tier,
    output logic [1:0]           o_quality_change
);

    localparam int TOTAL_W = FRAME_W + $clog2(WINDOW_LEN);
    localparam int LEN_W   = $clog2(WINDOW_LEN + 1);

    // Configuration registers
    logic            r_adaptive;
    logic [1:0]      r_manual;
    logic [19:0]     r_slow;
    logic [19:0]     r_fast;
    logic [CD_W-1:0] r_lower_cd;
    logic [CD_W-1:0] r_raise_cd;

    // Sequencer
    t_state    r_state;
    t_state    n_state;
    t_win_ctrl w_win;
    logic      w_accept;
    logic      w_div_start;
    logic      w_gov_en;
    logic      w_put;
    logic      w_out_free;

    // Block state
    logic [FRAME_W-1:0]   r_prev;
    logic [TOTAL_W-1:0]   r_total;
    logic [FRAMES_W-1:0]  r_frames;
    logic [ELAPSED_W-1:0] r_elapsed;
    logic [RATE_W-1:0]    r_rate;
    logic [1:0]           r_level;
    logic [CD_W-1:0]      r_cooldown;

    // Per-item work registers
    logic [FRAME_W-1:0] r_ftime;
    logic               r_hit;
    logic [NUMER_W-1:0] r_numer;

    // Result waiting for the output register
    logic [FRAME_W-1:0] r_res_ftime;
    logic [FRAME_W-1:0] r_res_avg;
    logic [RATE_W-1:0]  r_res_rate;
    logic               r_res_upd;
    logic [1:0]         r_res_level;
    logic [1:0]         r_res_change;

    // Output register
    logic               r_o_valid;
    logic [FRAME_W-1:0] r_o_ftime;
    logic [FRAME_W-1:0] r_o_avg;
    logic [RATE_W-1:0]  r_o_rate;
    logic               r_o_upd;
    logic [1:0]         r_o_level;
    logic [1:0]         r_o_change;

    // Window and dividers
    logic [FRAME_W-1:0] w_old;
    logic               w_avg_busy;
    logic [TOTAL_W-1:0] w_avg_quot;
    logic               w_rate_busy;
    logic [NUMER_W-1:0] w_rate_quot;

    // Governor next values
    logic [FRAME_W-1:0] w_avg;
    logic [RATE_W-1:0]  w_rate_sat;
    logic [1:0]         n_level;
    logic [CD_W-1:0]    w_cd_load;
    logic [CD_W-1:0]    n_cooldown;
    logic [1:0]         w_change;
    logic [NUMER_W-1:0] n_numer;

    ftqg_window #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_win),
        .i_wr_data (r_ftime),
        .o_old     (w_old)
    );

    ftqg_serial_div #(
        .N_W (TOTAL_W),
        .D_W (LEN_W)
    ) u_avg_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_numer (r_total),
        .i_denom (LEN_W'(WINDOW_LEN)),
        .o_busy  (w_avg_busy),
        .o_quot  (w_avg_quot)
    );

    ftqg_serial_div #(
        .N_W (NUMER_W),
        .D_W (ELAPSED_W)
    ) u_rate_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_numer (r_numer),
        .i_denom (r_elapsed),
        .o_busy  (w_rate_busy),
        .o_quot  (w_rate_quot)
    );

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adaptive <= RST_ADAPTIVE;
            r_manual   <= RST_MANUAL;
            r_slow     <= RST_SLOW;
            r_fast     <= RST_FAST;
            r_lower_cd <= RST_LOWER_CD;
            r_raise_cd <= RST_RAISE_CD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ADAPTIVE: r_adaptive <= i_cfg_data[0];
                REG_MANUAL:   r_manual   <= i_cfg_data[1:0];
                REG_SLOW:     r_slow     <= i_cfg_data[19:0];
                REG_FAST:     r_fast     <= i_cfg_data[19:0];
                REG_LOWER_CD: r_lower_cd <= i_cfg_data[CD_W-1:0];
                REG_RAISE_CD: r_raise_cd <= i_cfg_data[CD_W-1:0];
                default: ;
            endcase
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign w_out_free = !r_o_valid || !i_stall;

    // Next state and sequencer strobes.
    always_comb begin
        n_state     = r_state;
        w_accept    = 1'b0;
        w_win       = '0;
        w_div_start = 1'b0;
        w_gov_en    = 1'b0;
        w_put       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    w_accept     = 1'b1;
                    w_win.rd_en  = 1'b1;
                    n_state      = S_READ;
                end
            end
            S_READ: begin
                w_win.wr_en = 1'b1;
                n_state     = S_ADD;
            end
            S_ADD: begin
                n_state = S_START;
            end
            S_START: begin
                w_div_start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (!w_avg_busy && !w_rate_busy) begin
                    n_state = S_GOV;
                end
            end
            S_GOV: begin
                w_gov_en = 1'b1;
                n_state  = S_PUT;
            end
            S_PUT: begin
                if (w_out_free) begin
                    w_put   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

    // Quality decision on the fresh average.
    always_comb begin
        w_avg      = w_avg_quot[FRAME_W-1:0];
        w_rate_sat = (|w_rate_quot[NUMER_W-1:RATE_W]) ? RATE_MAX
                                                      : w_rate_quot[RATE_W-1:0];
        n_level    = r_level;
        w_cd_load  = r_cooldown;
        w_change   = CHG_NONE;
        if (r_adaptive) begin
            if (r_cooldown == '0) begin
                if (w_avg > FRAME_W'(r_slow)) begin
                    if (r_level != LVL_LOW) begin
                        n_level   = r_level - 1'b1;
                        w_cd_load = r_lower_cd;
                        w_change  = CHG_LOWERED;
                    end
                end else if (w_avg < FRAME_W'(r_fast)) begin
                    if (r_level != LVL_HIGH) begin
                        n_level   = r_level + 1'b1;
                        w_cd_load = r_raise_cd;
                        w_change  = CHG_RAISED;
                    end
                end
            end
        end else begin
            n_level = (r_manual == 2'd3) ? LVL_HIGH : r_manual;
        end
        n_cooldown = (w_cd_load != '0) ? (w_cd_load - 1'b1) : '0;
        n_numer    = NUMER_W'(r_frames) * NUMER_W'(RATE_SCALE);
    end

    // Block state updates, one step per sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_total    <= '0;
            r_frames   <= '0;
            r_elapsed  <= '0;
            r_rate     <= '0;
            r_level    <= LVL_HIGH;
            r_cooldown <= '0;
        end else begin
            if (w_accept) begin
                r_prev <= i_now_us;
            end
            if (r_state == S_READ) begin
                r_total   <= r_total - TOTAL_W'(w_old);
                r_elapsed <= r_elapsed + ELAPSED_W'(r_ftime);
                if (r_frames != FRAMES_MAX) begin
                    r_frames <= r_frames + 1'b1;
                end
            end
            if (r_state == S_ADD) begin
                r_total <= r_total + TOTAL_W'(r_ftime);
            end
            if (w_gov_en) begin
                r_level    <= n_level;
                r_cooldown <= n_cooldown;
                if (r_hit) begin
                    r_rate    <= w_rate_sat;
                    r_frames  <= '0;
                    r_elapsed <= '0;
                end
            end
        end
    end

    // Per-item work registers and the pending result.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ftime <= i_now_us - r_prev;
        end
        if (r_state == S_ADD) begin
            r_hit   <= (r_elapsed >= ONE_SECOND_US);
            r_numer <= n_numer;
        end
        if (w_gov_en) begin
            r_res_ftime  <= r_ftime;
            r_res_avg    <= w_avg;
            r_res_rate   <= r_hit ? w_rate_sat : r_rate;
            r_res_upd    <= r_hit;
            r_res_level  <= n_level;
            r_res_change <= w_change;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_put) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_put) begin
            r_o_ftime  <= r_res_ftime;
            r_o_avg    <= r_res_avg;
            r_o_rate   <= r_res_rate;
            r_o_upd    <= r_res_upd;
            r_o_level  <= r_res_level;
            r_o_change <= r_res_change;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_frame_time_us   = r_o_ftime;
    assign o_average_time_us = r_o_avg;
    assign o_fps_q4          = r_o_rate;
    assign o_fps_updated     = r_o_upd;
    assign o_quality_tier    = r_o_level;
    assign o_quality_change  = r_o_change;

    // The level never leaves its three legal values.
    `FTQG_ASSERT_IMPL(a_level_range, i_clk, i_rst_n, 1'b1, r_level <= LVL_HIGH)
    // A lowering can never leave the level at high.
    `FTQG_ASSERT_IMPL(a_lowered_level, i_clk, i_rst_n, o_valid && (o_quality_change == CHG_LOWERED), o_quality_tier != LVL_HIGH)
    // A completed rate measurement restarts the one-second interval.
    `FTQG_ASSERT_NEXT(a_elapsed_clear, i_clk, i_rst_n, w_gov_en && r_hit, (r_elapsed == '0) && (r_frames == '0))
    // No new item is taken while a division is running.
    `FTQG_ASSERT_IMPL(a_busy_stall, i_clk, i_rst_n, w_avg_busy || w_rate_busy, o_stall)

endmodule

// File: design/ftqg_serial_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Uses nothing from the package; instantiated by the top level.
module ftqg_serial_div #(
    parameter int N_W = 40,
    parameter int D_W = 33
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_numer,
    input  logic [D_W-1:0] i_denom,
    output logic           o_busy,
    output logic [N_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   r_quot;
    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_denom;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    logic [D_W:0]     w_rem_sh;
    logic [D_W:0]     w_diff;
    logic             w_ge;

    // Shift in the next numerator bit and try the subtraction.
    always_comb begin
        w_rem_sh = {r_rem, r_quot[N_W-1]};
        w_diff   = w_rem_sh - {1'b0, r_denom};
        w_ge     = (w_rem_sh >= {1'b0, r_denom});
    end

    // Control: the counter runs once per numerator bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(N_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath: numerator shifts out as quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot  <= i_numer;
            r_rem   <= '0;
            r_denom <= i_denom;
        end else if (r_busy) begin
            r_quot <= {r_quot[N_W-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[D_W-1:0] : w_rem_sh[D_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

// File: design/ftqg_window.sv
// Circular window of frame times with per-entry valid bits.
// Uses ftqg_pkg for widths and the control struct.
module ftqg_window
    import ftqg_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_win_ctrl          i_ctrl,
    input  logic [FRAME_W-1:0] i_wr_data,
    output logic [FRAME_W-1:0] o_old
);

    localparam int PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

    logic [FRAME_W-1:0]    r_mem [WINDOW_LEN];
    logic [WINDOW_LEN-1:0] r_valid;
    logic [PTR_W-1:0]      r_ptr;
    logic [FRAME_W-1:0]    r_rd_data;
    logic                  r_rd_ok;

    // Memory: registered read at the pointer, write at the pointer.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[r_ptr];
        end
        if (i_ctrl.wr_en) begin
            r_mem[r_ptr] <= i_wr_data;
        end
    end

    // Valid bits and pointer; an entry never written reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ptr   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_ctrl.rd_en) begin
                r_rd_ok <= r_valid[r_ptr];
            end
            if (i_ctrl.wr_en) begin
                r_valid[r_ptr] <= 1'b1;
                if (r_ptr == PTR_W'(WINDOW_LEN - 1)) begin
                    r_ptr <= '0;
                end else begin
                    r_ptr <= r_ptr + 1'b1;
                end
            end
        end
    end

    assign o_old = r_rd_ok ? r_rd_data : '0;

endmodule

// File: sim/frame_time_quality_governor_top_tb.sv
// Self-checking testbench for frame_time_quality_governor_top.
// Needs ftqg_pkg and the block's RTL. A directed table runs first, then random bursts
// of frame stamps. Each result is checked against an in-bench model or a hand-written value.
module frame_time_quality_governor_top_tb
    import ftqg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 20;
    localparam int WIN_LEN       = WINDOW_LEN_DEF;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int SETTLE_CYCLES = 200;
    localparam longint TIMEOUT_NS = 40_000_000;

    // Indexes past the last register; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_time_us;
        logic [FRAME_W-1:0] average_time_us;
        logic [RATE_W-1:0]  fps_q4;
        logic               fps_updated;
        logic [1:0]         quality_tier;
        logic [1:0]         quality_change;
    } t_gov_result;

    typedef enum logic {
        ROW_FRAME,
        ROW_REG
    } t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_data;
        logic [FRAME_W-1:0]   stamp;
        logic                 has_want;
        t_gov_result          want;
    } t_stim_row;

    // Clock, reset and block ports.
    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [FRAME_W-1:0]   now_us   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [FRAME_W-1:0]   res_frame_time;
    logic [FRAME_W-1:0]   res_average;
    logic [RATE_W-1:0]    res_fps;
    logic                 res_fps_updated;
    logic [1:0]           res_level;
    logic [1:0]           res_change;

    // A hand-written result travels with its item, like the payload.
    logic                 typed_valid  = 1'b0;
    t_gov_result          typed_result = '0;

    int unsigned send_idle_pct  = 25;
    int unsigned recv_stall_pct = 68;
    int unsigned mismatch_count = 0;

    t_gov_result pending_results[$];
    t_stim_row   dir_table[$];

    // Governor model: configuration.
    logic              gov_adaptive;
    logic [1:0]        gov_manual;
    logic [19:0]       slow_thr;
    logic [19:0]       fast_thr;
    logic [CD_W-1:0]   lower_cd;
    logic [CD_W-1:0]   raise_cd;

    // Governor model: state.
    logic [FRAME_W-1:0]  last_stamp;
    logic [FRAME_W-1:0]  frame_hist [WIN_LEN];
    int                  hist_ptr;
    logic [37:0]         hist_sum;
    logic [FRAMES_W-1:0] frame_count;
    logic [63:0]         span_us;
    logic [RATE_W-1:0]   rate_q4;
    logic [1:0]          cur_level;
    logic [CD_W-1:0]     cool_left;

    frame_time_quality_governor_top #(
        .WINDOW_LEN(WIN_LEN)
    ) DUT (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (cfg_data),
        .i_valid           (in_valid),
        .o_stall           (in_stall),
        .i_now_us          (now_us),
        .o_valid           (out_valid),
        .i_stall           (out_stall),
        .o_frame_time_us   (res_frame_time),
        .o_average_time_us (res_average),
        .o_fps_q4          (res_fps),
        .o_fps_updated     (res_fps_updated),
        .o_quality_tier    (res_level),
        .o_quality_change  (res_change)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Receiver: stalls at random with the current percentage.
    always @(posedge clk) begin
        out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // Model state after reset.
    function automatic void clear_predictor();
        gov_adaptive = RST_ADAPTIVE;
        gov_manual   = RST_MANUAL;
        slow_thr     = RST_SLOW;
        fast_thr     = RST_FAST;
        lower_cd     = RST_LOWER_CD;
        raise_cd     = RST_RAISE_CD;
        last_stamp   = '0;
        foreach (frame_hist[n]) frame_hist[n] = '0;
        hist_ptr     = 0;
        hist_sum     = '0;
        frame_count  = '0;
        span_us      = '0;
        rate_q4      = '0;
        cur_level    = LVL_HIGH;
        cool_left    = '0;
        pending_results.delete();
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] data);
        case (idx)
            REG_ADAPTIVE: gov_adaptive = data[0];
            REG_MANUAL:   gov_manual   = data[1:0];
            REG_SLOW:     slow_thr     = data[19:0];
            REG_FAST:     fast_thr     = data[19:0];
            REG_LOWER_CD: lower_cd     = data[CD_W-1:0];
            REG_RAISE_CD: raise_cd     = data[CD_W-1:0];
            default: ;
        endcase
    endfunction

    // Advances the model by one frame stamp and returns the result it produces.
    function automatic t_gov_result predict_frame(input logic [FRAME_W-1:0] stamp);
        t_gov_result res;
        logic [FRAME_W-1:0] dt;
        logic [63:0] rate;
        dt = stamp - last_stamp;
        last_stamp = stamp;

        // Circular window and its running total.
        hist_sum = hist_sum - frame_hist[hist_ptr] + dt;
        frame_hist[hist_ptr] = dt;
        hist_ptr = (hist_ptr + 1) % WIN_LEN;
        res.frame_time_us   = dt;
        res.average_time_us = FRAME_W'(hist_sum / 38'(WIN_LEN));
        res.fps_updated     = 1'b0;
        res.quality_change  = CHG_NONE;

        // Rate over roughly one second of frames.
        if (frame_count != FRAMES_MAX) frame_count = frame_count + 1'b1;
        span_us = span_us + 64'(dt);
        if (span_us >= 64'(ONE_SECOND_US)) begin
            rate = (64'(frame_count) * 64'(RATE_SCALE)) / span_us;
            rate_q4 = (rate > 64'(RATE_MAX)) ? RATE_MAX : rate[RATE_W-1:0];
            frame_count = '0;
            span_us = '0;
            res.fps_updated = 1'b1;
        end

        // Level steering with hysteresis and cooldown.
        if (gov_adaptive) begin
            if (cool_left == 0) begin
                if (res.average_time_us > FRAME_W'(slow_thr)) begin
                    if (cur_level > LVL_LOW) begin
                        cur_level = cur_level - 1'b1;
                        cool_left = lower_cd;
                        res.quality_change = CHG_LOWERED;
                    end
                end else if (res.average_time_us < FRAME_W'(fast_thr)) begin
                    if (cur_level < LVL_HIGH) begin
                        cur_level = cur_level + 1'b1;
                        cool_left = raise_cd;
                        res.quality_change = CHG_RAISED;
                    end
                end
            end
        end else begin
            cur_level = (gov_manual > LVL_HIGH) ? LVL_HIGH : gov_manual;
        end
        if (cool_left != 0) cool_left = cool_left - 1'b1;

        res.fps_q4 = rate_q4;
        res.quality_tier = cur_level;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("%0t ns: %s is %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic check_result(input t_gov_result got, input t_gov_result want);
        if (got.frame_time_us !== want.frame_time_us)
            report_mismatch("frame_time_us", got.frame_time_us, want.frame_time_us);
        if (got.average_time_us !== want.average_time_us)
            report_mismatch("average_time_us", got.average_time_us, want.average_time_us);
        if (got.fps_q4 !== want.fps_q4)
            report_mismatch("fps_q4", got.fps_q4, want.fps_q4);
        if (got.fps_updated !== want.fps_updated)
            report_mismatch("fps_updated", got.fps_updated, want.fps_updated);
        if (got.quality_tier !== want.quality_tier)
            report_mismatch("quality_tier", got.quality_tier, want.quality_tier);
        if (got.quality_change !== want.quality_change)
            report_mismatch("quality_change", got.quality_change, want.quality_change);
    endtask

    // Watches both channels and the register port at every edge.
    always @(posedge clk) begin : scoreboard
        t_gov_result got_res;
        t_gov_result predicted;
        if (!rst_n) begin
            clear_predictor();
        end else begin
            if (out_valid && !out_stall) begin
                got_res = {res_frame_time, res_average, res_fps, res_fps_updated,
                           res_level, res_change};
                if (pending_results.size() == 0)
                    report_mismatch("unrequested result frame_time_us", got_res.frame_time_us,
                                    '0);
                else
                    check_result(got_res, pending_results.pop_front());
            end
            if (cfg_we) apply_reg(cfg_idx, cfg_data);
            if (in_valid && !in_stall) begin
                predicted = predict_frame(now_us);
                pending_results.push_back(typed_valid ? typed_result : predicted);
            end
        end
    end

    function automatic bit chance(input int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic t_stim_row frame_row(input logic [FRAME_W-1:0] stamp);
        t_stim_row row;
        row = '0;
        row.kind = ROW_FRAME;
        row.stamp = stamp;
        return row;
    endfunction

    function automatic t_stim_row checked_row(input logic [FRAME_W-1:0] stamp,
                                              input t_gov_result want);
        t_stim_row row;
        row = frame_row(stamp);
        row.has_want = 1'b1;
        row.want = want;
        return row;
    endfunction

    function automatic t_stim_row reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] data);
        t_stim_row row;
        row = '0;
        row.kind = ROW_REG;
        row.reg_idx = idx;
        row.reg_data = data;
        return row;
    endfunction

    // Drops valid and the write enable, and waits until every result has come back.
    task automatic wait_drained();
        if (in_valid) in_valid <= 1'b0;
        if (cfg_we) cfg_we <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
        @(posedge clk);
    endtask

    // Consecutive writes keep the enable high; the next item or drain lowers it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // Presents one item, with optional idle cycles first, until it is taken.
    task automatic send_frame(input logic [FRAME_W-1:0] stamp, input logic has_want,
                              input t_gov_result want);
        if (cfg_we) cfg_we <= 1'b0;
        if (chance(send_idle_pct)) begin
            in_valid <= 1'b0;
            do @(posedge clk); while (chance(send_idle_pct));
        end
        in_valid     <= 1'b1;
        now_us       <= stamp;
        typed_valid  <= has_want;
        typed_result <= want;
        do @(posedge clk); while (in_stall);
    endtask

    // Time to the next frame: mostly near the burst's mean, with hitches and noise.
    function automatic logic [FRAME_W-1:0] frame_gap(input int unsigned mean_us);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 4) return '0;
        if (pick < 6) return $urandom;
        if (pick < 7) return -$urandom_range(40000, 1);
        if (pick < 9) return $urandom_range(1500000, 200000);
        return $urandom_range(mean_us + mean_us / 4, mean_us - mean_us / 4);
    endfunction

    function automatic logic [CFG_W-1:0] pick_threshold(input int unsigned lo,
                                                        input int unsigned hi);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 85) return CFG_W'($urandom_range(hi, lo));
        if (pick < 90) return '0;
        if (pick < 95) return CFG_W'(1000000);
        return CFG_W'($urandom_range(1000000));
    endfunction

    function automatic logic [CFG_W-1:0] pick_cooldown();
        int unsigned pick;
        logic [3:0] junk;
        pick = $urandom_range(99);
        junk = 4'($urandom);
        if (pick < 60) return {junk, 16'($urandom_range(8))};
        if (pick < 90) return {junk, 16'($urandom_range(200, 9))};
        return {junk, 16'($urandom_range(2000, 201))};
    endfunction

    // Random register changes between bursts; the block is idle here.
    task automatic retune_governor();
        if (chance(40))
            write_reg(REG_ADAPTIVE, {19'($urandom), 1'(chance(85))});
        if (chance(30)) write_reg(REG_MANUAL, CFG_W'($urandom));
        if (chance(40)) write_reg(REG_SLOW, pick_threshold(14000, 30000));
        if (chance(40)) write_reg(REG_FAST, pick_threshold(6000, 17000));
        if (chance(40)) write_reg(REG_LOWER_CD, pick_cooldown());
        if (chance(40)) write_reg(REG_RAISE_CD, pick_cooldown());
        if (chance(10))
            write_reg(chance(50) ? REG_SPARE_6 : REG_SPARE_7, CFG_W'($urandom));
    endtask

    initial begin : stimulus
        logic [FRAME_W-1:0] stamp_cursor;
        int unsigned mode;
        int unsigned sent;
        int unsigned burst_len;
        int unsigned mean_us;

        // Directed table: first frame, extremes, wrap, repeats, manual mode,
        // ignored register indexes and register extremes.
        dir_table.push_back(checked_row(32'h0000_0000,
            {32'd0, 32'd0, 20'd0, 1'b0, LVL_HIGH, CHG_NONE}));
        dir_table.push_back(checked_row(32'hFFFF_FFFF,
            {32'hFFFF_FFFF, 32'd71582788, 20'd0, 1'b1, LVL_MED, CHG_LOWERED}));
        dir_table.push_back(frame_row(32'h0000_0000));
        dir_table.push_back(frame_row(32'h0000_0000));
        dir_table.push_back(frame_row(32'd16667));
        dir_table.push_back(frame_row(32'd33334));
        dir_table.push_back(reg_row(REG_ADAPTIVE, 20'hFFFFE));
        dir_table.push_back(reg_row(REG_MANUAL, 20'hFFFFF));
        dir_table.push_back(frame_row(32'd50001));
        dir_table.push_back(reg_row(REG_MANUAL, 20'd0));
        dir_table.push_back(frame_row(32'd66668));
        dir_table.push_back(reg_row(REG_MANUAL, 20'd1));
        dir_table.push_back(frame_row(32'h7FFF_FFFF));
        dir_table.push_back(reg_row(REG_SPARE_6, 20'hFFFFF));
        dir_table.push_back(reg_row(REG_SPARE_7, 20'h00000));
        dir_table.push_back(frame_row(32'h8000_0000));
        dir_table.push_back(reg_row(REG_ADAPTIVE, 20'd1));
        dir_table.push_back(reg_row(REG_SLOW, 20'd0));
        dir_table.push_back(reg_row(REG_FAST, 20'd1000000));
        dir_table.push_back(reg_row(REG_LOWER_CD, 20'hFFFF));
        dir_table.push_back(reg_row(REG_RAISE_CD, 20'hFFFF));
        dir_table.push_back(frame_row(32'hAAAA_AAAA));
        dir_table.push_back(frame_row(32'h5555_5555));
        dir_table.push_back(reg_row(REG_SLOW, 20'd1000000));
        dir_table.push_back(reg_row(REG_FAST, 20'd0));
        dir_table.push_back(reg_row(REG_LOWER_CD, 20'd0));
        dir_table.push_back(reg_row(REG_RAISE_CD, 20'd0));
        dir_table.push_back(frame_row(32'hFFFF_FFF0));
        dir_table.push_back(frame_row(32'h0000_0010));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_table[n]) begin
            if (dir_table[n].kind == ROW_REG) begin
                if (in_valid) wait_drained();
                write_reg(dir_table[n].reg_idx, dir_table[n].reg_data);
            end else begin
                send_frame(dir_table[n].stamp, dir_table[n].has_want, dir_table[n].want);
            end
        end
        stamp_cursor = 32'h0000_0010;

        // Random bursts of frames around a chosen mean, under three idle patterns.
        for (mode = 0; mode < 3; mode++) begin
            send_idle_pct  = (mode == 0) ? 25 : (mode == 1) ? 68 : 0;
            recv_stall_pct = (mode == 0) ? 68 : (mode == 1) ? 25 : 0;
            sent = 0;
            while (sent < RANDOM_ITEMS / 3) begin
                wait_drained();
                retune_governor();
                burst_len = $urandom_range(120, 30);
                if (burst_len > RANDOM_ITEMS / 3 - sent) burst_len = RANDOM_ITEMS / 3 - sent;
                mean_us = $urandom_range(40000, 6000);
                repeat (burst_len) begin
                    stamp_cursor = stamp_cursor + frame_gap(mean_us);
                    send_frame(stamp_cursor, 1'b0, '0);
                    sent++;
                end
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule
